>>> sv/svpwm_pkg.sv
// svpwm_pkg: shared types and constants of the space vector pwm compare block
// no dependencies; used by every module of the block except svpwm_div
package svpwm_pkg;

   localparam int VOLT_W  = 16;
   localparam int BUS_W   = 15;
   localparam int COUNT_W = 16;
   localparam int NUM_W   = 32;   // magnitude of an active time numerator
   localparam int TIME_W  = 33;   // active time before rescale
   localparam int SUM_W   = 34;
   localparam int PER_W   = 17;   // time in Q1.16 of one period, up to one

   localparam logic signed [33:0] SQRT3_HALF_Q16 = 34'sd56756;
   localparam logic [16:0]        SQRT3_Q16      = 17'd113512;
   localparam logic [PER_W-1:0]   ONE_PERIOD     = 17'd65536;
   localparam logic [PER_W-1:0]   HALF_PERIOD    = 17'd32768;

   // register indexes of the csr port
   localparam logic [1:0] CSR_BUS_MIN  = 2'd0;
   localparam logic [1:0] CSR_PERIOD   = 2'd1;
   localparam logic [1:0] CSR_CMP_MAX  = 2'd2;
   localparam logic [1:0] CSR_NEUTRAL  = 2'd3;

   // sector codes from the three sign tests
   localparam logic [2:0] SECTOR_1 = 3'd1;
   localparam logic [2:0] SECTOR_2 = 3'd2;
   localparam logic [2:0] SECTOR_3 = 3'd3;
   localparam logic [2:0] SECTOR_4 = 3'd4;
   localparam logic [2:0] SECTOR_5 = 3'd5;
   localparam logic [2:0] SECTOR_6 = 3'd6;

   typedef struct packed {
      logic signed [VOLT_W-1:0] volt_alpha;
      logic signed [VOLT_W-1:0] volt_beta;
      logic [BUS_W-1:0]         bus_volts;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] compare_a;
      logic [COUNT_W-1:0] compare_b;
      logic [COUNT_W-1:0] compare_c;
      logic [2:0]         sector_code;
      logic               bus_low;
   } rsp_type;

   typedef struct packed {
      logic [BUS_W-1:0]   bus_min_volts;
      logic [COUNT_W-1:0] period_counts;
      logic [COUNT_W-1:0] compare_max;
      logic [COUNT_W-1:0] neutral_compare;
   } cfg_type;

   // classified request passed from front to back
   typedef struct packed {
      logic             bus_low;
      logic [2:0]       sector;
      logic [BUS_W-1:0] bus;
      logic [NUM_W-1:0] num1;
      logic [NUM_W-1:0] num2;
   } item_type;

endpackage

>>> sv/space_vector_pwm_compare.sv
// space_vector_pwm_compare: seven-segment space vector pwm compare generator
// depends on svpwm_pkg, svpwm_fifo, svpwm_front, svpwm_back and svpwm_div
//
// usage:
//   requests (alpha, beta, bus volts) are pushed with req_push while req_full
//   is low. results appear in order on rsp_data while rsp_empty is low and
//   are taken with rsp_pop. csr_we/csr_index/csr_wdata write the four
//   registers (bus minimum, period counts, compare maximum, neutral compare)
//   and should only be written while no request is in flight.
// timing:
//   the front takes a request every cycle while req_full is low, into a
//   four-entry queue. the back handles one request at a time and takes a new
//   one only after the last result has been loaded for output. a normal
//   vector runs the first bit-serial divider stage (33 steps), a rescale also
//   the second (17 steps), and a low bus neither.
// reset:
//   synchronous reset empties the queue and output register and loads the
//   register defaults. when rsp_pop is held low the back holds two finished
//   results, one of them waiting; the queue fills and then req_full rises.
module space_vector_pwm_compare (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  svpwm_pkg::req_type req_data,
   output logic               req_full,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output svpwm_pkg::rsp_type rsp_data,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   svpwm_pkg::cfg_type  cfg_ff, cfg_in;
   svpwm_pkg::item_type push_item, head_item;
   logic                q_push, q_full, q_pop, q_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            svpwm_pkg::CSR_BUS_MIN: cfg_in.bus_min_volts   = csr_wdata[14:0];
            svpwm_pkg::CSR_PERIOD:  cfg_in.period_counts   = csr_wdata;
            svpwm_pkg::CSR_CMP_MAX: cfg_in.compare_max     = csr_wdata;
            svpwm_pkg::CSR_NEUTRAL: cfg_in.neutral_compare = csr_wdata;
            default:                cfg_in                 = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bus_min_volts   <= 15'd0;
         cfg_ff.period_counts   <= 16'd1000;
         cfg_ff.compare_max     <= 16'd1000;
         cfg_ff.neutral_compare <= 16'd500;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   svpwm_front u_front (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_data(req_data), .req_full(req_full),
      .cfg(cfg_ff), .q_full(q_full), .q_push(q_push), .q_data(push_item)
   );

   svpwm_fifo #(.DEPTH(4)) u_fifo (
      .clock(clock), .reset(reset),
      .push(q_push), .push_data(push_item), .full(q_full),
      .pop(q_pop), .pop_data(head_item), .empty(q_empty)
   );

   svpwm_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .q_empty(q_empty), .q_data(head_item), .q_pop(q_pop),
      .rsp_pop(rsp_pop), .rsp_empty(rsp_empty), .rsp_data(rsp_data)
   );

endmodule

>>> sv/svpwm_fifo.sv
// svpwm_fifo: small register queue of classified requests between front and back
// depends on svpwm_pkg for item_type
module svpwm_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  svpwm_pkg::item_type push_data,
   output logic                full,
   input  logic                pop,
   output svpwm_pkg::item_type pop_data,
   output logic                empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   svpwm_pkg::item_type mem_ff [DEPTH];
   logic [AW:0] wr_ptr_ff, wr_ptr_in;
   logic [AW:0] rd_ptr_ff, rd_ptr_in;

   assign empty    = (wr_ptr_ff == rd_ptr_ff);
   assign full     = (wr_ptr_ff[AW] != rd_ptr_ff[AW]) &&
                     (wr_ptr_ff[AW-1:0] == rd_ptr_ff[AW-1:0]);
   assign pop_data = mem_ff[rd_ptr_ff[AW-1:0]];

   assign wr_ptr_in = (push && !full) ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = (pop && !empty) ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[wr_ptr_ff[AW-1:0]] <= push_data;
      end
   end

endmodule

>>> sv/svpwm_div.sv
// svpwm_div: restoring divider, one quotient bit per cycle
// stand-alone; the remainder start value must be below the divisor
module svpwm_div #(
   parameter int QW = 33,
   parameter int DW = 15
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] rem_init,
   input  logic [QW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [QW-1:0] quotient
);

   localparam int CW = $clog2(QW + 1);

   logic [DW-1:0] rem_ff, rem_in;
   logic [QW-1:0] dvd_ff, dvd_in;
   logic [DW-1:0] dsr_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [DW:0]   shifted;
   logic [DW:0]   trial;

   assign shifted  = {rem_ff, dvd_ff[QW-1]};
   assign trial    = shifted - {1'b0, dsr_ff};
   assign done     = done_ff;
   assign quotient = dvd_ff;

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = rem_init;
         dvd_in = dividend;
         cnt_in = CW'(QW);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!trial[DW]) begin
            rem_in = trial[DW-1:0];
         end else begin
            rem_in = shifted[DW-1:0];
         end
         dvd_in = {dvd_ff[QW-2:0], ~trial[DW]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      if (start) begin
         dsr_ff <= divisor;
      end
   end

endmodule

>>> sv/svpwm_front.sv
// svpwm_front: takes requests, checks the bus, finds the sector and the two
// active time numerators; depends on svpwm_pkg
module svpwm_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  svpwm_pkg::req_type  req_data,
   output logic                req_full,
   input  svpwm_pkg::cfg_type  cfg,
   input  logic                q_full,
   output logic                q_push,
   output svpwm_pkg::item_type q_data
);

   logic                     valid_ff, valid_in;
   logic signed [33:0]       ca_ff, ca_in;
   logic signed [15:0]       beta_ff;
   logic [svpwm_pkg::BUS_W-1:0] bus_ff;
   logic                     low_ff, low_in;
   logic                     advance;

   logic signed [33:0] hb, u1, u2, u3, ny, nz, n1, n2;
   logic [2:0]         sector;

   function automatic logic [svpwm_pkg::NUM_W-1:0] clamp_pos(input logic signed [33:0] n);
      if (n > 34'sd0) begin
         return n[svpwm_pkg::NUM_W-1:0];
      end
      return '0;
   endfunction

   assign advance  = !valid_ff || !q_full;
   assign req_full = !advance;
   assign valid_in = advance ? req_push : valid_ff;
   assign ca_in    = 34'(req_data.volt_alpha) * svpwm_pkg::SQRT3_HALF_Q16;
   assign low_in   = (req_data.bus_volts == '0) ||
                     (req_data.bus_volts < cfg.bus_min_volts);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ca_ff   <= ca_in;
         beta_ff <= req_data.volt_beta;
         bus_ff  <= req_data.bus_volts;
         low_ff  <= low_in;
      end
   end

   // all terms in Q.16 volts
   assign hb = $signed({{3{beta_ff[15]}}, beta_ff, 15'b0});
   assign u1 = $signed({{2{beta_ff[15]}}, beta_ff, 16'b0});
   assign u2 = ca_ff - hb;
   assign u3 = -ca_ff - hb;
   assign ny = ca_ff + hb;
   assign nz = hb - ca_ff;

   assign sector = {(u3 > 34'sd0), (u2 > 34'sd0), (u1 > 34'sd0)};

   always_comb begin
      unique case (sector)
         svpwm_pkg::SECTOR_1: begin n1 = nz;  n2 = ny;  end
         svpwm_pkg::SECTOR_2: begin n1 = ny;  n2 = -u1; end
         svpwm_pkg::SECTOR_3: begin n1 = -nz; n2 = u1;  end
         svpwm_pkg::SECTOR_4: begin n1 = -u1; n2 = nz;  end
         svpwm_pkg::SECTOR_5: begin n1 = u1;  n2 = -ny; end
         svpwm_pkg::SECTOR_6: begin n1 = -ny; n2 = -nz; end
         default:             begin n1 = '0;  n2 = '0;  end
      endcase
   end

   assign q_push         = valid_ff && !q_full;
   assign q_data.bus_low = low_ff;
   assign q_data.sector  = low_ff ? 3'd0 : sector;
   assign q_data.bus     = bus_ff;
   assign q_data.num1    = low_ff ? '0 : clamp_pos(n1);
   assign q_data.num2    = low_ff ? '0 : clamp_pos(n2);

endmodule

>>> sv/svpwm_back.sv
// svpwm_back: sequencer that turns a classified request into three compares
// depends on svpwm_pkg and svpwm_div
module svpwm_back (
   input  logic                clock,
   input  logic                reset,
   input  svpwm_pkg::cfg_type  cfg,
   input  logic                q_empty,
   input  svpwm_pkg::item_type q_data,
   output logic                q_pop,
   input  logic                rsp_pop,
   output logic                rsp_empty,
   output svpwm_pkg::rsp_type  rsp_data
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MUL   = 4'd1;
   localparam logic [3:0] S_DIV1S = 4'd2;
   localparam logic [3:0] S_DIV1W = 4'd3;
   localparam logic [3:0] S_SUM   = 4'd4;
   localparam logic [3:0] S_DIV2W = 4'd5;
   localparam logic [3:0] S_MAP   = 4'd6;
   localparam logic [3:0] S_MUL2  = 4'd7;
   localparam logic [3:0] S_CLIP  = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;

   localparam int TW = svpwm_pkg::TIME_W;
   localparam int PW = svpwm_pkg::PER_W;
   localparam int SW = svpwm_pkg::SUM_W;

   logic [3:0]  state_ff, state_in;
   svpwm_pkg::item_type item_ff;
   logic [TW-1:0] q1_ff, q2_ff, t1_ff, t2_ff;
   logic [PW-1:0] s1_ff, s2_ff;
   logic [PW-1:0] ta_ff, tb_ff, tc_ff;
   logic [32:0]   pa_ff, pb_ff, pc_ff;
   svpwm_pkg::rsp_type res_ff, res_in;
   svpwm_pkg::rsp_type out_ff;
   logic          out_valid_ff, out_valid_in;

   logic [48:0]   prod1, prod2;
   logic [SW-1:0] sum;
   logic          div1_start, div1_done_a, div1_done_b;
   logic [TW-1:0] div1_q_a, div1_q_b;
   logic          div2_start, div2_done_a, div2_done_b;
   logic [PW-1:0] div2_q_a, div2_q_b;
   logic [PW:0]   idle_time;
   logic [PW-1:0] p1, p2, p3;
   logic [PW-1:0] ca_cmp, cb_cmp, cc_cmp;
   logic          out_load;

   function automatic logic [svpwm_pkg::COUNT_W-1:0] clip(input logic [32:0] p,
                                                          input logic [15:0] lim);
      if (p[32:16] > {1'b0, lim}) begin
         return lim;
      end
      return p[31:16];
   endfunction

   assign prod1 = 49'(item_ff.num1) * 49'(svpwm_pkg::SQRT3_Q16);
   assign prod2 = 49'(item_ff.num2) * 49'(svpwm_pkg::SQRT3_Q16);
   assign sum   = SW'(t1_ff) + SW'(t2_ff);

   assign div1_start = (state_ff == S_DIV1S);
   assign div2_start = (state_ff == S_SUM) && (sum > SW'(svpwm_pkg::ONE_PERIOD));

   // active time = floor(num * sqrt3 / 2^16) / bus
   svpwm_div #(.QW(TW), .DW(svpwm_pkg::BUS_W)) u_div1_a (
      .clock(clock), .reset(reset), .start(div1_start), .rem_init('0),
      .dividend(q1_ff), .divisor(item_ff.bus), .done(div1_done_a), .quotient(div1_q_a)
   );
   svpwm_div #(.QW(TW), .DW(svpwm_pkg::BUS_W)) u_div1_b (
      .clock(clock), .reset(reset), .start(div1_start), .rem_init('0),
      .dividend(q2_ff), .divisor(item_ff.bus), .done(div1_done_b), .quotient(div1_q_b)
   );

   // rescale t * 2^16 / sum; t <= sum so the quotient needs 17 bits
   svpwm_div #(.QW(PW), .DW(SW)) u_div2_a (
      .clock(clock), .reset(reset), .start(div2_start),
      .rem_init(SW'(t1_ff[TW-1:1])), .dividend({t1_ff[0], 16'b0}),
      .divisor(sum), .done(div2_done_a), .quotient(div2_q_a)
   );
   svpwm_div #(.QW(PW), .DW(SW)) u_div2_b (
      .clock(clock), .reset(reset), .start(div2_start),
      .rem_init(SW'(t2_ff[TW-1:1])), .dividend({t2_ff[0], 16'b0}),
      .divisor(sum), .done(div2_done_b), .quotient(div2_q_b)
   );

   assign idle_time = {1'b0, svpwm_pkg::ONE_PERIOD} - {1'b0, s1_ff} - {1'b0, s2_ff};
   assign p1 = PW'(idle_time[PW:2]);
   assign p2 = p1 + {1'b0, s1_ff[PW-1:1]};
   assign p3 = p2 + {1'b0, s2_ff[PW-1:1]};

   always_comb begin
      unique case (item_ff.sector)
         svpwm_pkg::SECTOR_1: begin ca_cmp = p2; cb_cmp = p1; cc_cmp = p3; end
         svpwm_pkg::SECTOR_2: begin ca_cmp = p1; cb_cmp = p3; cc_cmp = p2; end
         svpwm_pkg::SECTOR_3: begin ca_cmp = p1; cb_cmp = p2; cc_cmp = p3; end
         svpwm_pkg::SECTOR_4: begin ca_cmp = p3; cb_cmp = p2; cc_cmp = p1; end
         svpwm_pkg::SECTOR_5: begin ca_cmp = p3; cb_cmp = p1; cc_cmp = p2; end
         svpwm_pkg::SECTOR_6: begin ca_cmp = p2; cb_cmp = p3; cc_cmp = p1; end
         default: begin
            ca_cmp = svpwm_pkg::HALF_PERIOD;
            cb_cmp = svpwm_pkg::HALF_PERIOD;
            cc_cmp = svpwm_pkg::HALF_PERIOD;
         end
      endcase
   end

   assign q_pop    = (state_ff == S_IDLE) && !q_empty;
   assign out_load = (state_ff == S_OUT) && (!out_valid_ff || rsp_pop);

   always_comb begin
      state_in = state_ff;
      res_in   = res_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               if (q_data.bus_low) begin
                  res_in.compare_a   = cfg.neutral_compare;
                  res_in.compare_b   = cfg.neutral_compare;
                  res_in.compare_c   = cfg.neutral_compare;
                  res_in.sector_code = 3'd0;
                  res_in.bus_low     = 1'b1;
                  state_in           = S_OUT;
               end else begin
                  state_in = S_MUL;
               end
            end
         end
         S_MUL:   state_in = S_DIV1S;
         S_DIV1S: state_in = S_DIV1W;
         S_DIV1W: begin
            if (div1_done_a && div1_done_b) begin
               state_in = S_SUM;
            end
         end
         S_SUM:   state_in = div2_start ? S_DIV2W : S_MAP;
         S_DIV2W: begin
            if (div2_done_a && div2_done_b) begin
               state_in = S_MAP;
            end
         end
         S_MAP:   state_in = S_MUL2;
         S_MUL2:  state_in = S_CLIP;
         S_CLIP: begin
            res_in.compare_a   = clip(pa_ff, cfg.compare_max);
            res_in.compare_b   = clip(pb_ff, cfg.compare_max);
            res_in.compare_c   = clip(pc_ff, cfg.compare_max);
            res_in.sector_code = item_ff.sector;
            res_in.bus_low     = 1'b0;
            state_in           = S_OUT;
         end
         S_OUT: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign out_valid_in = out_load || (out_valid_ff && !rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (q_pop) begin
         item_ff <= q_data;
      end
      if (state_ff == S_MUL) begin
         q1_ff <= prod1[48:16];
         q2_ff <= prod2[48:16];
      end
      if (state_ff == S_DIV1W && div1_done_a) begin
         t1_ff <= div1_q_a;
         t2_ff <= div1_q_b;
      end
      if (state_ff == S_SUM && !div2_start) begin
         s1_ff <= t1_ff[PW-1:0];
         s2_ff <= t2_ff[PW-1:0];
      end
      if (state_ff == S_DIV2W && div2_done_a) begin
         s1_ff <= div2_q_a;
         s2_ff <= div2_q_b;
      end
      if (state_ff == S_MAP) begin
         ta_ff <= ca_cmp;
         tb_ff <= cb_cmp;
         tc_ff <= cc_cmp;
      end
      if (state_ff == S_MUL2) begin
         pa_ff <= 33'(ta_ff) * 33'(cfg.period_counts);
         pb_ff <= 33'(tb_ff) * 33'(cfg.period_counts);
         pc_ff <= 33'(tc_ff) * 33'(cfg.period_counts);
      end
      if (out_load) begin
         out_ff <= res_ff;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule
